// ----- hw/rtl/rac_pkg.sv -----
// Shared types and constants for the region average color block.
package rac_pkg;

	localparam int COORD_W = 11;
	localparam int REG_W   = 12;
	localparam int EXT_W   = 11;
	localparam int COLOR_W = 8;
	localparam int SUM_W   = 30;
	localparam int CNT_W   = 23;

	localparam int MAX_FRAME_WIDTH  = 2048;
	localparam int MAX_FRAME_HEIGHT = 2048;

	// tally saturates here; sums then stay within SUM_W bits
	localparam logic [CNT_W-1:0] TALLY_CAP = CNT_W'(4194304);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register map of the cfg port
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_TOP    = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	typedef struct packed {
		logic signed [REG_W-1:0] left;
		logic signed [REG_W-1:0] top;
		logic [EXT_W-1:0]        width;
		logic [EXT_W-1:0]        height;
	} cfg_t;

	typedef struct packed {
		logic               in_region;
		logic               last;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] red_sum;
		logic [SUM_W-1:0] green_sum;
		logic [SUM_W-1:0] blue_sum;
		logic [CNT_W-1:0] tally;
	} totals_t;

endpackage

// ----- hw/rtl/rac_if.sv -----
// Stream interfaces: pixel words in, mean color words out.
interface rac_pixel_if;
	logic        valid;
	logic        ready;
	logic [10:0] pixel_x;
	logic [10:0] pixel_y;
	logic [7:0]  pixel_blue;
	logic [7:0]  pixel_green;
	logic [7:0]  pixel_red;
	logic        last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_blue, pixel_green, pixel_red,
		last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_blue, pixel_green, pixel_red,
		last_pixel, output ready);
endinterface

interface rac_mean_if;
	logic        valid;
	logic        ready;
	logic [7:0]  mean_red;
	logic [7:0]  mean_green;
	logic [7:0]  mean_blue;
	logic [22:0] inside_count;
	logic        region_empty;

	modport source (output valid, mean_red, mean_green, mean_blue, inside_count,
		region_empty, input ready);
	modport sink (input valid, mean_red, mean_green, mean_blue, inside_count,
		region_empty, output ready);
endinterface

// ----- hw/rtl/rac_front.sv -----
// Front end: takes pixel words and tags each one as inside or outside the region.
module rac_front import rac_pkg::*; (
	input  cfg_t         cfg,
	rac_pixel_if.sink    pixel_in,
	input  logic         q_full,
	output logic         push,
	output item_t        item
);

	localparam logic [13:0] FRAME_W_LIM = 14'(MAX_FRAME_WIDTH);
	localparam logic [13:0] FRAME_H_LIM = 14'(MAX_FRAME_HEIGHT);

	logic [COORD_W-1:0] lo_x, lo_y;
	logic [COORD_W:0]   hi_x, hi_y;
	logic               in_x, in_y;

	// negative start clips to zero; far edge follows the clipped start
	assign lo_x = cfg.left[REG_W-1] ? '0 : cfg.left[COORD_W-1:0];
	assign lo_y = cfg.top[REG_W-1]  ? '0 : cfg.top[COORD_W-1:0];
	assign hi_x = {1'b0, lo_x} + {1'b0, cfg.width};
	assign hi_y = {1'b0, lo_y} + {1'b0, cfg.height};

	assign in_x = (pixel_in.pixel_x >= lo_x) && ({1'b0, pixel_in.pixel_x} <= hi_x) &&
		({3'b000, pixel_in.pixel_x} < FRAME_W_LIM);
	assign in_y = (pixel_in.pixel_y >= lo_y) && ({1'b0, pixel_in.pixel_y} <= hi_y) &&
		({3'b000, pixel_in.pixel_y} < FRAME_H_LIM);

	assign pixel_in.ready = !q_full;
	assign push           = pixel_in.valid && !q_full;

	always_comb begin
		item.in_region = in_x && in_y;
		item.last      = pixel_in.last_pixel;
		item.red       = pixel_in.pixel_red;
		item.green     = pixel_in.pixel_green;
		item.blue      = pixel_in.pixel_blue;
	end

endmodule

// ----- hw/rtl/rac_queue.sv -----
// Small FIFO between the classifier and the accumulator.
module rac_queue import rac_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rac_accum.sv -----
// Back end: running channel sums and tally; hands frame totals to the divider.
module rac_accum import rac_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  item_t   head,
	output logic    pop,
	input  logic    div_ready,
	output logic    frame_valid,
	output totals_t frame
);

	totals_t acc_q;
	logic    add;

	// a frame end waits until the divider is free
	assign pop = !q_empty && (!head.last || div_ready);
	assign add = head.in_region && (acc_q.tally < TALLY_CAP);

	always_comb begin
		frame.red_sum   = acc_q.red_sum   + (add ? SUM_W'(head.red)   : '0);
		frame.green_sum = acc_q.green_sum + (add ? SUM_W'(head.green) : '0);
		frame.blue_sum  = acc_q.blue_sum  + (add ? SUM_W'(head.blue)  : '0);
		frame.tally     = acc_q.tally     + (add ? CNT_W'(1)          : '0);
	end

	assign frame_valid = pop && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (pop) begin
			acc_q <= head.last ? '0 : frame;
		end
	end

endmodule

// ----- hw/rtl/rac_div.sv -----
// Radix-2 restoring divider, three channels in lockstep, with the result register.
module rac_div import rac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  totals_t    frame,
	output logic       ready,
	rac_mean_if.source mean_out
);

	typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

	state_t                         state_q;
	logic [2:0][SUM_W-1:0]          rem_q;
	logic [2:0][SUM_W-1:0]          rem_n;
	logic [2:0]                     ge;
	logic [SUM_W-1:0]               divisor_q;
	logic [2:0][COLOR_W-1:0]        quo_q;
	logic [$clog2(COLOR_W)-1:0]     step_q;
	logic [CNT_W-1:0]               count_q;
	logic                           empty_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ge[c]    = (rem_q[c] >= divisor_q);
			rem_n[c] = ge[c] ? rem_q[c] - divisor_q : rem_q[c];
		end
	end

	assign ready                 = (state_q == IDLE);
	assign mean_out.valid        = (state_q == HOLD);
	assign mean_out.mean_red     = quo_q[0];
	assign mean_out.mean_green   = quo_q[1];
	assign mean_out.mean_blue    = quo_q[2];
	assign mean_out.inside_count = count_q;
	assign mean_out.region_empty = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			rem_q     <= '0;
			divisor_q <= '0;
			quo_q     <= '0;
			step_q    <= '0;
			count_q   <= '0;
			empty_q   <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						count_q <= frame.tally;
						quo_q   <= '0;
						if (frame.tally == '0) begin
							// nothing counted: black, no division
							empty_q <= 1'b1;
							state_q <= HOLD;
						end else begin
							empty_q   <= 1'b0;
							rem_q     <= {frame.blue_sum, frame.green_sum, frame.red_sum};
							// mean fits 8 bits, so start at divisor * 2^7
							divisor_q <= {frame.tally, {(SUM_W-CNT_W){1'b0}}};
							step_q    <= '1;
							state_q   <= RUN;
						end
					end
				end
				RUN: begin
					rem_q     <= rem_n;
					divisor_q <= divisor_q >> 1;
					for (int c = 0; c < 3; c++) begin
						quo_q[c] <= {quo_q[c][COLOR_W-2:0], ge[c]};
					end
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= HOLD;
					end
				end
				HOLD: begin
					if (mean_out.ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/region_average_color_core.sv -----
// Top level of the region average color block.
//
//   channel    | dir | word                                        | accepted when
//   -----------+-----+---------------------------------------------+----------------------
//   pixel_in   | in  | x, y, blue, green, red, last_pixel          | valid && ready
//   mean_out   | out | mean r/g/b, inside_count, region_empty      | valid && ready
//   cfg        | in  | cfg_index, cfg_data (left/top/width/height) | cfg_wr_en
//
// Pixels: one word per cycle sustained. The input side only stalls when the
//   four-entry queue fills, which happens while a frame end waits on the divider.
// Frame end: a load step plus 8 divider iterations (one quotient bit per cycle
//   for all three channels), then the result sits in the output register.
//   An empty region skips the iterations. The next frame keeps accumulating meanwhile.
// Reset: arst_n clears config, sums, tally, queue and divider state at once.
// Stalls: the output register holds its word until mean_out.ready; a second frame
//   end stalls in the queue until then.
module region_average_color_core import rac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [11:0] cfg_data,
	rac_pixel_if.sink  pixel_in,
	rac_mean_if.source mean_out
);

	cfg_t    cfg_q;
	logic    push, pop, q_full, q_empty;
	item_t   push_item, head;
	logic    div_ready, frame_valid;
	totals_t frame;

	// region registers; the user must write them only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LEFT:   cfg_q.left   <= cfg_data;
				REG_TOP:    cfg_q.top    <= cfg_data;
				REG_WIDTH:  cfg_q.width  <= cfg_data[EXT_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[EXT_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// classify: inside test against the clipped rectangle and frame bounds
	rac_front u_front (
		.cfg      (cfg_q),
		.pixel_in (pixel_in),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	// decouples the pixel stream from the frame-end division
	rac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// sums and tally; totals handed over on the last pixel
	rac_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (head),
		.pop         (pop),
		.div_ready   (div_ready),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

	// per-frame means and the output word register
	rac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (frame_valid),
		.frame    (frame),
		.ready    (div_ready),
		.mean_out (mean_out)
	);

endmodule

// ----- hw/rtl/rac_checker.sv -----
// Port-level assertions for the region average color block, bound to the top level.
module rac_checker import rac_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COLOR_W-1:0] mean_red,
	input logic [COLOR_W-1:0] mean_green,
	input logic [COLOR_W-1:0] mean_blue,
	input logic [CNT_W-1:0]   inside_count,
	input logic               region_empty
);

	// a result word stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before acceptance");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mean_red) && $stable(mean_green) &&
			$stable(mean_blue) && $stable(inside_count) && $stable(region_empty))
		else $error("result payload changed while stalled");

	// empty region reports black with a zero count
	a_empty_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_empty |-> inside_count == '0 && mean_red == '0 &&
			mean_green == '0 && mean_blue == '0)
		else $error("empty region result is not black");

	// a non-empty result has counted pixels
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !region_empty |-> inside_count != '0)
		else $error("non-empty result with zero count");

	// tally saturates at its cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inside_count <= TALLY_CAP)
		else $error("inside count beyond cap");

endmodule

bind region_average_color_core rac_checker u_rac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (mean_out.valid),
	.out_ready    (mean_out.ready),
	.mean_red     (mean_out.mean_red),
	.mean_green   (mean_out.mean_green),
	.mean_blue    (mean_out.mean_blue),
	.inside_count (mean_out.inside_count),
	.region_empty (mean_out.region_empty)
);

// ----- sim/region_average_color_core_tb.sv -----
// Self-checking testbench for region_average_color_core: random pixel frames against a local predictor.
`timescale 1ns / 100ps

module region_average_color_core_tb;
	import rac_pkg::*;

	// idle cycles before a register write; they cover the frame end and the queue
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PIXELS = 850;

	typedef enum logic [1:0] {OP_PIXEL, OP_CFG, OP_DRAIN} op_kind_t;

	// one entry of the driver's work list: a pixel word, a register write, or a drain
	typedef struct {
		op_kind_t             kind;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COLOR_W-1:0]   blue;
		logic [COLOR_W-1:0]   green;
		logic [COLOR_W-1:0]   red;
		logic                 last;
		logic [1:0]           index;
		logic [REG_W-1:0]     data;
	} stim_t;

	typedef struct {
		logic [COLOR_W-1:0] mean_red;
		logic [COLOR_W-1:0] mean_green;
		logic [COLOR_W-1:0] mean_blue;
		logic [CNT_W-1:0]   inside_count;
		logic               region_empty;
	} mean_word_t;

	logic clk;
	logic arst_n = 1'b0;

	// everything the testbench drives starts at a known value
	logic             pix_valid  = 1'b0;
	logic             mean_ready = 1'b0;
	logic             cfg_wr_en  = 1'b0;
	logic [1:0]       cfg_index  = REG_LEFT;
	logic [REG_W-1:0] cfg_data   = '0;
	stim_t            pix_word   = '{kind: OP_PIXEL, default: '0};

	// handshakes seen at the last rising edge, read by the falling-edge drivers
	logic pix_took  = 1'b0;
	logic mean_took = 1'b0;

	rac_pixel_if pix_bus ();
	rac_mean_if  mean_bus ();

	assign pix_bus.valid       = pix_valid;
	assign pix_bus.pixel_x     = pix_word.x;
	assign pix_bus.pixel_y     = pix_word.y;
	assign pix_bus.pixel_blue  = pix_word.blue;
	assign pix_bus.pixel_green = pix_word.green;
	assign pix_bus.pixel_red   = pix_word.red;
	assign pix_bus.last_pixel  = pix_word.last;
	assign mean_bus.ready      = mean_ready;

	region_average_color_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel_in (pix_bus),
		.mean_out (mean_bus)
	);

	// ---------------------------------------------------------------
	// Predictor state: region registers and per-frame accumulators
	// ---------------------------------------------------------------
	logic signed [REG_W-1:0] roi_left   = '0;
	logic signed [REG_W-1:0] roi_top    = '0;
	logic [EXT_W-1:0]        roi_width  = '0;
	logic [EXT_W-1:0]        roi_height = '0;

	logic [SUM_W-1:0] acc_red   = '0;
	logic [SUM_W-1:0] acc_green = '0;
	logic [SUM_W-1:0] acc_blue  = '0;
	logic [CNT_W-1:0] acc_count = '0;

	stim_t      pending[$];     // work list for the driver
	mean_word_t want_means[$];  // mean words still owed by the block

	int mismatch_count = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	int settle_count   = 0;
	bit steady_run     = 1'b0;  // when set, both sides run without idling

	// generator-side copy of the current region, used to aim pixels at it
	int gen_lo_x = 0, gen_hi_x = 0, gen_lo_y = 0, gen_hi_y = 0;

	// random wait before one word; now and then switch into a burst stretch
	function automatic int draw_wait();
		if ($urandom_range(0, 39) == 0)
			steady_run = ~steady_run;
		return steady_run ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [REG_W-1:0] data);
		case (idx)
			REG_LEFT:   roi_left   = data;
			REG_TOP:    roi_top    = data;
			REG_WIDTH:  roi_width  = data[EXT_W-1:0];
			REG_HEIGHT: roi_height = data[EXT_W-1:0];
			default: ;
		endcase
	endfunction

	// inclusive span test; a negative start clips to 0 and drags the far edge along
	function automatic bit in_span(logic [COORD_W-1:0] p, logic signed [REG_W-1:0] start,
			logic [EXT_W-1:0] extent, int limit);
		logic [REG_W:0] lo;
		logic [REG_W:0] hi;
		lo = start[REG_W-1] ? '0 : {1'b0, start};
		hi = lo + (REG_W+1)'(extent);
		return ({2'b00, p} >= lo) && ({2'b00, p} <= hi) && (int'(p) < limit);
	endfunction

	// fold one accepted pixel into the sums; on the last pixel owe a mean word
	function automatic void fold_pixel(stim_t p);
		mean_word_t       w;
		logic [SUM_W-1:0] q;
		if (in_span(p.x, roi_left, roi_width, MAX_FRAME_WIDTH) &&
				in_span(p.y, roi_top, roi_height, MAX_FRAME_HEIGHT) &&
				acc_count < TALLY_CAP) begin
			acc_red   = acc_red + SUM_W'(p.red);
			acc_green = acc_green + SUM_W'(p.green);
			acc_blue  = acc_blue + SUM_W'(p.blue);
			acc_count = acc_count + 1'b1;
		end
		if (p.last) begin
			if (acc_count == 0) begin
				// nothing landed in the region: black, zero count, empty flag
				w = '{mean_red: '0, mean_green: '0, mean_blue: '0,
					inside_count: '0, region_empty: 1'b1};
			end else begin
				q = acc_red / SUM_W'(acc_count);
				w.mean_red = q[COLOR_W-1:0];
				q = acc_green / SUM_W'(acc_count);
				w.mean_green = q[COLOR_W-1:0];
				q = acc_blue / SUM_W'(acc_count);
				w.mean_blue = q[COLOR_W-1:0];
				w.inside_count = acc_count;
				w.region_empty = 1'b0;
			end
			want_means.push_back(w);
			acc_red   = '0;
			acc_green = '0;
			acc_blue  = '0;
			acc_count = '0;
		end
	endfunction

	function automatic void report(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
		end
	endfunction

	function automatic void check_mean();
		mean_word_t w;
		if (want_means.size() == 0) begin
			mismatch_count++;
			$display("%0t unexpected mean word: expected none actual r=%0d g=%0d b=%0d n=%0d e=%0d",
				$time, mean_bus.mean_red, mean_bus.mean_green, mean_bus.mean_blue,
				mean_bus.inside_count, mean_bus.region_empty);
			return;
		end
		w = want_means.pop_front();
		report("mean_red", w.mean_red, mean_bus.mean_red);
		report("mean_green", w.mean_green, mean_bus.mean_green);
		report("mean_blue", w.mean_blue, mean_bus.mean_blue);
		report("inside_count", w.inside_count, mean_bus.inside_count);
		report("region_empty", w.region_empty, mean_bus.region_empty);
	endfunction

	// ---------------------------------------------------------------
	// Work list builders
	// ---------------------------------------------------------------
	task automatic add_pixel(int x, int y, int b, int g, int r, bit last);
		stim_t s;
		s = '{kind: OP_PIXEL, default: '0};
		s.x     = COORD_W'(x);
		s.y     = COORD_W'(y);
		s.blue  = COLOR_W'(b);
		s.green = COLOR_W'(g);
		s.red   = COLOR_W'(r);
		s.last  = last;
		pending.push_back(s);
	endtask

	// drain first so the block is idle, then write all four registers
	task automatic add_regs(int left, int top, int width, int height);
		stim_t s;
		logic signed [REG_W-1:0] l;
		logic signed [REG_W-1:0] t;
		s = '{kind: OP_DRAIN, default: '0};
		pending.push_back(s);
		l = REG_W'(left);
		t = REG_W'(top);
		s.kind = OP_CFG;
		s.index = REG_LEFT;   s.data = l;               pending.push_back(s);
		s.index = REG_TOP;    s.data = t;               pending.push_back(s);
		s.index = REG_WIDTH;  s.data = REG_W'(width);   pending.push_back(s);
		s.index = REG_HEIGHT; s.data = REG_W'(height);  pending.push_back(s);
		gen_lo_x = (l < 0) ? 0 : int'(l);
		gen_lo_y = (t < 0) ? 0 : int'(t);
		gen_hi_x = gen_lo_x + (width & 12'h7FF);
		gen_hi_y = gen_lo_y + (height & 12'h7FF);
	endtask

	// mostly near the region so the inside path gets real traffic
	function automatic int aim(int lo, int hi);
		int a, b;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 2047);
		a = (lo > 2) ? lo - 2 : 0;
		b = (hi + 2 < 2047) ? hi + 2 : 2047;
		if (a > 2047)
			a = 2047;
		return $urandom_range(a, b);
	endfunction

	task automatic pick_region();
		int l, t, w, h;
		case ($urandom_range(0, 7))
			0: begin  // extremes of the register ranges
				l = $urandom_range(0, 1) ? -2048 : 2047;
				t = $urandom_range(0, 1) ? -2048 : 2047;
				w = $urandom_range(0, 1) ? 0 : 2047;
				h = $urandom_range(0, 1) ? 0 : 2047;
			end
			1: begin  // negative starts, clipped
				l = -$urandom_range(1, 2048);
				t = -$urandom_range(1, 2048);
				w = $urandom_range(0, 15);
				h = $urandom_range(0, 15);
			end
			default: begin
				l = int'($signed(12'($urandom)));
				t = int'($signed(12'($urandom)));
				w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 12);
				h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 12);
			end
		endcase
		add_regs(l, t, w, h);
	endtask

	// ---------------------------------------------------------------
	// Clock and run time limit
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b1;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// Rising edge: record handshakes, run predictor, check mean words
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pix_took  <= pix_valid && pix_bus.ready;
		mean_took <= mean_bus.valid && mean_ready;
		if (arst_n) begin
			if (pix_valid && pix_bus.ready)
				fold_pixel(pix_word);
			if (mean_bus.valid && mean_ready)
				check_mean();
		end
	end

	// ---------------------------------------------------------------
	// Falling edge: pixel and cfg driver, fed from the work list
	// ---------------------------------------------------------------
	always @(negedge clk) begin : pixel_side
		logic nv;
		logic nw;
		nv = pix_valid;
		nw = 1'b0;
		if (pix_valid && pix_took)
			nv = 1'b0;
		if (arst_n && !nv && pending.size() > 0) begin
			case (pending[0].kind)
				OP_PIXEL: begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						pix_word <= pending[0];
						nv = 1'b1;
						void'(pending.pop_front());
						gap_left = draw_wait();
					end
				end
				OP_CFG: begin
					// block is idle here; predictor takes the write at once
					nw = 1'b1;
					cfg_index <= pending[0].index;
					cfg_data  <= pending[0].data;
					apply_reg(pending[0].index, pending[0].data);
					void'(pending.pop_front());
				end
				OP_DRAIN: begin
					// hold off until every mean word is in, then let the queue settle
					if (want_means.size() != 0) begin
						settle_count = 0;
					end else if (settle_count < SETTLE_CYCLES) begin
						settle_count++;
					end else begin
						settle_count = 0;
						void'(pending.pop_front());
					end
				end
				default: ;
			endcase
		end
		pix_valid <= nv;
		cfg_wr_en <= nw;
	end

	// result side: random stall before each word
	always @(negedge clk) begin : mean_side
		logic nr;
		nr = mean_ready;
		if (mean_ready && mean_took) begin
			stall_left = draw_wait();
			nr = 1'b0;
		end
		if (!nr) begin
			if (stall_left == 0)
				nr = 1'b1;
			else
				stall_left--;
		end
		if (arst_n)
			mean_ready <= nr;
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		int made;
		int frames;
		int len;

		// reset values: region is the single pixel (0,0); repeats count again
		add_pixel(0, 0, 255, 255, 255, 1'b0);
		add_pixel(1, 0, 10, 10, 10, 1'b0);
		add_pixel(0, 1, 20, 20, 20, 1'b0);
		add_pixel(0, 0, 1, 2, 3, 1'b1);

		// whole frame, starts at the most negative value
		add_regs(-2048, -2048, 2047, 2047);
		add_pixel(2047, 2047, 0, 0, 0, 1'b0);
		add_pixel(0, 0, 255, 255, 255, 1'b0);
		add_pixel(1024, 1000, 8'h55, 8'hAA, 8'h0F, 1'b0);
		add_pixel(2047, 0, 8'hF0, 8'h33, 8'hCC, 1'b1);

		// corner region; a frame that misses it gives black and the empty flag
		add_regs(2047, 2047, 0, 0);
		add_pixel(2046, 2047, 200, 100, 50, 1'b1);
		add_pixel(2047, 2047, 7, 8, 9, 1'b1);

		// clipped start pulls the far edge in: columns 0..3, row 0 only
		add_regs(-5, -1, 3, 0);
		add_pixel(3, 0, 90, 91, 92, 1'b0);
		add_pixel(4, 0, 255, 255, 255, 1'b0);
		add_pixel(0, 1, 255, 255, 255, 1'b0);
		add_pixel(2, 0, 11, 12, 13, 1'b1);

		// far edge past the frame bound
		add_regs(100, 200, 2047, 2047);
		add_pixel(2047, 2047, 1, 1, 1, 1'b0);
		add_pixel(99, 200, 250, 250, 250, 1'b0);
		add_pixel(100, 199, 250, 250, 250, 1'b0);
		add_pixel(100, 200, 4, 5, 6, 1'b1);

		// random frames, a few frames per region setting
		made = 0;
		while (made < RANDOM_PIXELS) begin
			pick_region();
			frames = $urandom_range(1, 6);
			repeat (frames) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					add_pixel(aim(gen_lo_x, gen_hi_x), aim(gen_lo_y, gen_hi_y),
						$urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), i == len - 1);
				made += len;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || pix_valid)
			@(posedge clk);
		while (want_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && want_means.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
